// ----- hw/rtl/pdird_pkg.sv -----
// Package for the pulse-distance IR frame decoder.
// Holds the event class codes and fixed field widths; no dependencies.
`default_nettype none

package pdird_pkg;

  localparam int unsigned TICKS_W = 16;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned CNT_W   = 6;
  // wide enough for 97 units at the largest unit length
  localparam int unsigned CMP_W   = 24;

  localparam logic [CNT_W-1:0] ADDR_LATCH_COUNT = CNT_W'(16);
  localparam logic [CNT_W-1:0] FRAME_COUNT      = CNT_W'(32);
  localparam logic [CMD_W:0]   CMD_CHECK_SUM    = (CMD_W+1)'(8'hff);

  typedef enum logic [2:0] {
    CLS_ZERO_BIT = 3'd0,
    CLS_ONE_BIT  = 3'd1,
    CLS_ABORT    = 3'd2,
    CLS_IGNORE   = 3'd3,
    CLS_OVERFLOW = 3'd4
  } evt_class_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pdird_classify.sv -----
// Interval classifier for the IR frame decoder.
// Maps one event to a bit, abort, ignore or overflow class; uses pdird_pkg.
`default_nettype none

module pdird_classify
  import pdird_pkg::*;
#(
  parameter int unsigned UNIT_TICKS = 375
) (
  input  wire logic               mode,
  input  wire logic [TICKS_W-1:0] interval_ticks,
  output evt_class_t              evt_class
);

  // unit boundaries: units == n  <=>  n*U <= ticks < (n+1)*U
  localparam logic [CMP_W-1:0] T_1  = CMP_W'(UNIT_TICKS);
  localparam logic [CMP_W-1:0] T_2  = CMP_W'(2 * UNIT_TICKS);
  localparam logic [CMP_W-1:0] T_3  = CMP_W'(3 * UNIT_TICKS);
  localparam logic [CMP_W-1:0] T_9  = CMP_W'(9 * UNIT_TICKS);
  localparam logic [CMP_W-1:0] T_13 = CMP_W'(13 * UNIT_TICKS);
  localparam logic [CMP_W-1:0] T_14 = CMP_W'(14 * UNIT_TICKS);
  localparam logic [CMP_W-1:0] T_97 = CMP_W'(97 * UNIT_TICKS);

  logic [CMP_W-1:0] ticks_ext;

  assign ticks_ext = CMP_W'(interval_ticks);

  always_comb begin
    if (mode) begin
      evt_class = CLS_OVERFLOW;
    end else if (ticks_ext < T_1) begin
      evt_class = CLS_ABORT;
    end else if (ticks_ext < T_2) begin
      evt_class = CLS_ZERO_BIT;
    end else if (ticks_ext < T_3) begin
      evt_class = CLS_ONE_BIT;
    end else if (ticks_ext < T_9) begin
      evt_class = CLS_ABORT;
    end else if (ticks_ext < T_13) begin
      evt_class = CLS_IGNORE;
    end else if (ticks_ext < T_14) begin
      evt_class = CLS_ABORT;
    end else if (ticks_ext < T_97) begin
      evt_class = CLS_IGNORE;
    end else begin
      evt_class = CLS_ABORT;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pulse_distance_ir_frame_decoder_core.sv -----
// Pulse-distance (NEC-style) IR frame decoder, top level.
// Uses pdird_pkg and pdird_classify.
//
// Input stream: one transfer per receiver event. in_tuser is the mode
// (0 = edge interval, 1 = capture timer overflow), in_tdata the interval in
// timer ticks. Every input transfer yields exactly one output transfer.
// Output stream: out_tuser carries the frame flags, out_tdata the command,
// the latched address and the bit count after the event.
// cfg_data writes the expected address (reset 0xFF00); cfg_ready is always
// high. Write it only while no event is in flight.
// The interval class is registered first, then the shift/count step writes
// the output register.
// Throughput: one event per cycle while the receiver keeps out_tready high.
// Reset clears the pipeline, the bit count, shift word and address word.
// When the receiver stalls, the output register holds and the input stage
// fills; in_tready drops only while both stages are full and stalled.
`default_nettype none

module pulse_distance_ir_frame_decoder_core
  import pdird_pkg::*;
#(
  parameter int unsigned UNIT_TICKS = 375
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,     // [15:0] expected_address
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [15:0] interval_ticks
  input  wire logic        in_tuser,     // [0] mode
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [7:0] command, [23:8] address,
                                         // [29:24] bits_received, [31:30] zero
  output logic [2:0]       out_tuser     // [0] frame_valid, [1] frame_error,
                                         // [2] address_mismatch
);

  evt_class_t         cls_in;
  evt_class_t         cls_r;
  logic               s1_valid_r;
  logic               out_valid_r;
  logic               advance;
  logic               step;

  logic [ADDR_W-1:0]  exp_addr_r;
  logic [ADDR_W-1:0]  shift_r, shift_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]   count_step;

  logic               flag_valid_nxt, flag_error_nxt, flag_mism_nxt;
  logic [CMD_W-1:0]   cmd_nxt;
  logic [CMD_W:0]     cmd_sum;

  logic [2:0]         flags_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [CNT_W-1:0]   out_count_r;

  pdird_classify #(
    .UNIT_TICKS(UNIT_TICKS)
  ) u_classify (
    .mode          (in_tuser),
    .interval_ticks(in_tdata),
    .evt_class     (cls_in)
  );

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;

  // shift/count step on the registered class
  always_comb begin
    shift_nxt      = shift_r;
    count_step     = count_r;
    addr_nxt       = addr_r;
    flag_valid_nxt = 1'b0;
    flag_error_nxt = 1'b0;
    flag_mism_nxt  = 1'b0;
    cmd_nxt        = '0;
    cmd_sum        = '0;

    case (cls_r)
      CLS_ZERO_BIT: begin
        shift_nxt  = {1'b0, shift_r[ADDR_W-1:1]};
        count_step = count_r + CNT_W'(1);
      end
      CLS_ONE_BIT: begin
        shift_nxt  = {1'b1, shift_r[ADDR_W-1:1]};
        count_step = count_r + CNT_W'(1);
      end
      CLS_ABORT, CLS_OVERFLOW: begin
        count_step = '0;
      end
      default: begin
      end
    endcase

    if (cls_r != CLS_OVERFLOW && count_step == ADDR_LATCH_COUNT) begin
      addr_nxt = shift_nxt;
    end

    count_nxt = count_step;
    if (count_step == FRAME_COUNT) begin
      cmd_nxt = shift_nxt[CMD_W-1:0];
      cmd_sum = {1'b0, shift_nxt[CMD_W-1:0]} + {1'b0, shift_nxt[2*CMD_W-1:CMD_W]};
      if (cmd_sum != CMD_CHECK_SUM) begin
        flag_error_nxt = 1'b1;
      end else if (addr_nxt == exp_addr_r) begin
        flag_valid_nxt = 1'b1;
      end else begin
        flag_mism_nxt = 1'b1;
      end
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      exp_addr_r  <= 16'hff00;
      shift_r     <= '0;
      count_r     <= '0;
      addr_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        exp_addr_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        shift_r <= shift_nxt;
        count_r <= count_nxt;
        addr_r  <= addr_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cls_r <= cls_in;
    end
    if (step) begin
      flags_r     <= {flag_mism_nxt, flag_error_nxt, flag_valid_nxt};
      cmd_r       <= cmd_nxt;
      out_addr_r  <= addr_nxt;
      out_count_r <= count_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = flags_r;
  assign out_tdata  = {2'b00, out_count_r, out_addr_r, cmd_r};

endmodule

`default_nettype wire

// ----- hw/rtl/pdird_checker.sv -----
// Port-level checker for the IR frame decoder, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module pdird_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tuser))
    else $error("more than one frame flag");

  a_flag_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29:24] != 6'd32 |-> out_tuser == 3'b000 && out_tdata[7:0] == 8'h00)
    else $error("frame report without 32 bits");

  a_frame_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29:24] == 6'd32 |-> $onehot(out_tuser))
    else $error("completed frame without a verdict");

endmodule

bind pulse_distance_ir_frame_decoder_core pdird_checker u_pdird_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for pulse_distance_ir_frame_decoder_core: interval and
// timeout events, NEC-style frames and noise, every result predicted in-bench.
// Depends on pdird_pkg and the core RTL.
module tb;
  import pdird_pkg::*;

  localparam int unsigned UNIT        = 375;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned NUM_PHASES  = 6;

  typedef struct packed {
    logic              frame_valid;
    logic              frame_error;
    logic              addr_mismatch;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  bits;
  } ir_result_t;

  typedef struct packed {
    logic               mode;
    logic [TICKS_W-1:0] ticks;
    logic               typed;
    logic [CNT_W-1:0]   bits;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  // decoder state as seen by the bench
  logic [ADDR_W-1:0] rx_shift;
  logic [ADDR_W-1:0] rx_addr;
  logic [ADDR_W-1:0] want_addr;
  logic [CNT_W-1:0]  rx_bits;

  ir_result_t  pending_results[$];
  stim_row_t   dir_rows[$];
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  bit          send_calm  = 1'b0;
  bit          recv_calm  = 1'b0;

  pulse_distance_ir_frame_decoder_core #(
    .UNIT_TICKS(UNIT)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic evt_class_t classify(input logic mode, input logic [TICKS_W-1:0] ticks);
    int unsigned units;
    units = ticks / UNIT;
    if (mode)
      return CLS_OVERFLOW;
    if (units == 1)
      return CLS_ZERO_BIT;
    if (units == 2)
      return CLS_ONE_BIT;
    if (units == 13 || units < 9 || units > 96)
      return CLS_ABORT;
    return CLS_IGNORE;
  endfunction

  // advance the bench's decoder state by one event and return its result
  function automatic ir_result_t decode_event(input logic mode,
                                              input logic [TICKS_W-1:0] ticks);
    ir_result_t r;
    evt_class_t cls;
    cls = classify(mode, ticks);
    r = '0;
    case (cls)
      CLS_ZERO_BIT: begin
        rx_shift = {1'b0, rx_shift[ADDR_W-1:1]};
        rx_bits  = rx_bits + 1'b1;
      end
      CLS_ONE_BIT: begin
        rx_shift = {1'b1, rx_shift[ADDR_W-1:1]};
        rx_bits  = rx_bits + 1'b1;
      end
      CLS_ABORT, CLS_OVERFLOW: begin
        rx_bits = '0;
      end
      default: begin
      end
    endcase
    // latch also fires on an ignored length while the count sits at 16
    if (cls != CLS_OVERFLOW && rx_bits == ADDR_LATCH_COUNT)
      rx_addr = rx_shift;
    r.bits = rx_bits;
    if (rx_bits == FRAME_COUNT) begin
      r.command = rx_shift[CMD_W-1:0];
      if ({1'b0, rx_shift[CMD_W-1:0]} + {1'b0, rx_shift[2*CMD_W-1:CMD_W]} != CMD_CHECK_SUM)
        r.frame_error = 1'b1;
      else if (rx_addr == want_addr)
        r.frame_valid = 1'b1;
      else
        r.addr_mismatch = 1'b1;
      rx_bits = '0;
    end
    r.address = rx_addr;
    return r;
  endfunction

  function automatic void add_row(input logic mode, input logic [TICKS_W-1:0] ticks,
                                  input logic typed, input logic [CNT_W-1:0] bits);
    stim_row_t row;
    row.mode  = mode;
    row.ticks = ticks;
    row.typed = typed;
    row.bits  = bits;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input logic mode, input logic [TICKS_W-1:0] ticks,
                           input logic typed, input logic [CNT_W-1:0] typed_bits);
    int unsigned gap;
    ir_result_t  r;
    if ($urandom_range(0, 49) == 0)
      send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ticks;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    r = decode_event(mode, ticks);
    if (typed) begin
      r      = '0;
      r.bits = typed_bits;
    end
    pending_results.push_back(r);
    items_sent++;
  endtask

  task automatic send_noise();
    logic [TICKS_W-1:0] t;
    if ($urandom_range(0, 1))
      t = TICKS_W'($urandom_range(0, 65535));
    else
      t = TICKS_W'($urandom_range(0, 20) * UNIT + $urandom_range(0, UNIT - 1));
    send_item($urandom_range(0, 7) == 0, t, 1'b0, '0);
  endtask

  task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic [CMD_W-1:0] cmd,
                            input logic [CMD_W-1:0] cmd_inv);
    logic [31:0] word;
    int unsigned cut;
    word = {cmd_inv, cmd, addr};
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 32;
    // timeout between frames, then the leader
    if ($urandom_range(0, 4) != 0)
      send_item(1'b1, TICKS_W'($urandom_range(0, 65535)), 1'b0, '0);
    send_item(1'b0, TICKS_W'($urandom_range(14 * UNIT, 97 * UNIT - 1)), 1'b0, '0);
    for (int i = 0; i < 32; i++) begin
      if (i == cut) begin
        // drop the rest of the frame on a timeout or a bad length
        if ($urandom_range(0, 1))
          send_item(1'b1, TICKS_W'($urandom_range(0, 65535)), 1'b0, '0);
        else
          send_item(1'b0, TICKS_W'($urandom_range(3 * UNIT, 9 * UNIT - 1)), 1'b0, '0);
        return;
      end
      if ($urandom_range(0, 15) == 0)
        send_item(1'b0, TICKS_W'($urandom_range(9 * UNIT, 13 * UNIT - 1)), 1'b0, '0);
      send_item(1'b0, TICKS_W'(word[i] ? $urandom_range(2 * UNIT, 3 * UNIT - 1)
                                       : $urandom_range(UNIT, 2 * UNIT - 1)), 1'b0, '0);
    end
  endtask

  task automatic run_phase();
    int unsigned        start;
    logic [ADDR_W-1:0]  addr;
    logic [CMD_W-1:0]   cmd;
    logic [CMD_W-1:0]   cmd_inv;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        addr    = want_addr;
        cmd     = CMD_W'($urandom);
        cmd_inv = ~cmd;
        if ($urandom_range(0, 3) == 0)
          addr = ADDR_W'($urandom);
        if ($urandom_range(0, 3) == 0)
          cmd_inv = CMD_W'($urandom);
        send_frame(addr, cmd, cmd_inv);
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic write_expected_addr(input logic [ADDR_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    want_addr = value;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want_v,
                           input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  initial begin
    int unsigned gap;
    ir_result_t  got;
    ir_result_t  want;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0)
        recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.frame_valid   = out_tuser[0];
      got.frame_error   = out_tuser[1];
      got.addr_mismatch = out_tuser[2];
      got.command       = out_tdata[7:0];
      got.address       = out_tdata[23:8];
      got.bits          = out_tdata[29:24];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got tuser=%h tdata=%h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = pending_results.pop_front();
        cmp_field("frame_valid", want.frame_valid, got.frame_valid);
        cmp_field("frame_error", want.frame_error, got.frame_error);
        cmp_field("address_mismatch", want.addr_mismatch, got.addr_mismatch);
        cmp_field("command", want.command, got.command);
        cmp_field("address", want.address, got.address);
        cmp_field("bits_received", want.bits, got.bits);
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] cfg_val;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    rx_shift  = '0;
    rx_addr   = '0;
    rx_bits   = '0;
    want_addr = 16'hFF00;

    // mode, ticks, typed, bits_received
    add_row(1'b1, 16'd0,     1'b1, 6'd0);  // timeout straight after reset
    add_row(1'b0, 16'd0,     1'b1, 6'd0);  // zero units aborts
    add_row(1'b0, 16'd375,   1'b1, 6'd1);
    add_row(1'b0, 16'd749,   1'b1, 6'd2);
    add_row(1'b0, 16'd750,   1'b1, 6'd3);
    add_row(1'b0, 16'd1124,  1'b1, 6'd4);
    add_row(1'b0, 16'd3375,  1'b1, 6'd4);  // 9 units: ignored
    add_row(1'b0, 16'd4500,  1'b1, 6'd4);  // 12 units: ignored
    add_row(1'b0, 16'd4875,  1'b1, 6'd0);  // 13 units aborts
    add_row(1'b0, 16'd375,   1'b1, 6'd1);
    add_row(1'b0, 16'd5250,  1'b1, 6'd1);  // 14 units: ignored
    add_row(1'b0, 16'd36000, 1'b1, 6'd1);  // 96 units: ignored
    add_row(1'b0, 16'd36375, 1'b1, 6'd0);  // 97 units aborts
    add_row(1'b0, 16'd1125,  1'b0, 6'd0);
    add_row(1'b0, 16'd750,   1'b0, 6'd0);
    add_row(1'b0, 16'd3000,  1'b0, 6'd0);
    add_row(1'b0, 16'd3374,  1'b0, 6'd0);
    add_row(1'b0, 16'd750,   1'b0, 6'd0);
    add_row(1'b0, 16'd4874,  1'b0, 6'd0);
    add_row(1'b0, 16'd65535, 1'b0, 6'd0);
    add_row(1'b1, 16'd65535, 1'b0, 6'd0);
    add_row(1'b0, 16'd374,   1'b0, 6'd0);
    add_row(1'b0, 16'd376,   1'b0, 6'd0);
    add_row(1'b1, 16'h5555,  1'b0, 6'd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k])
      send_item(dir_rows[k].mode, dir_rows[k].ticks, dir_rows[k].typed, dir_rows[k].bits);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: cfg_val = 16'h0000;
          2: cfg_val = 16'hFFFF;
          4: cfg_val = 16'hFF00;
          default: cfg_val = ADDR_W'($urandom);
        endcase
        write_expected_addr(cfg_val);
      end
      run_phase();
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pdird_pkg.sv
hw/rtl/pdird_classify.sv
hw/rtl/pulse_distance_ir_frame_decoder_core.sv
hw/rtl/pdird_checker.sv
bench/tb.sv
